>>> rtl/irtp_pkg.sv
// shared types, constants and the character classifier for the init record text parser
// no dependencies
package irtp_pkg;

  localparam int MaxRecords   = 64;
  localparam int MaxDataBytes = 128;

  localparam int ValCntMax = MaxDataBytes + 3;
  localparam int ValCntW   = $clog2(ValCntMax + 1);
  localparam int RecCntW   = $clog2(MaxRecords + 1);

  localparam int InQDepth = 2;
  localparam int InQAw    = $clog2(InQDepth);
  localparam int InQCntW  = $clog2(InQDepth + 1);

  localparam int OutQDepth = 4;
  localparam int OutQAw    = $clog2(OutQDepth);
  localparam int OutQCntW  = $clog2(OutQDepth + 1);

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharNl    = 8'h0a;
  localparam logic [7:0] CharVt    = 8'h0b;
  localparam logic [7:0] CharFf    = 8'h0c;
  localparam logic [7:0] CharCr    = 8'h0d;
  localparam logic [7:0] CharSp    = 8'h20;
  localparam logic [7:0] CharComma = 8'h2c;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;
  localparam logic [7:0] CharUpX   = 8'h58;
  localparam logic [7:0] CharLoA   = 8'h61;
  localparam logic [7:0] CharLoF   = 8'h66;
  localparam logic [7:0] CharLoX   = 8'h78;
  localparam logic [7:0] CharOpen  = 8'h7b;
  localparam logic [7:0] CharClose = 8'h7d;

  typedef enum logic [2:0] {
    KindDelay  = 3'd0,
    KindCmd    = 3'd1,
    KindData   = 3'd2,
    KindOk     = 3'd3,
    KindSyntax = 3'd4,
    KindFew    = 3'd5,
    KindFull   = 3'd6,
    KindMany   = 3'd7
  } kind_e;

  typedef struct packed {
    logic       first;
    logic       nul;
    logic       space;
    logic       newline;
    logic       comma;
    logic       open;
    logic       close;
    logic       xchar;
    logic       zero;
    logic       dec;
    logic       hex;
    logic [3:0] digit;
  } char_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
    logic [6:0]  data_index;
    logic [5:0]  record_slot;
    logic        last;
  } result_t;

  function automatic char_t classify(input logic [7:0] c, input logic first);
    char_t r;
    logic  lo_hex;
    logic  up_hex;
    r       = '0;
    r.first = first;
    r.nul   = (c == CharNul);
    r.space = (c == CharSp) || (c == CharTab) || (c == CharNl) || (c == CharVt) ||
              (c == CharFf) || (c == CharCr);
    r.newline = (c == CharNl);
    r.comma = (c == CharComma);
    r.open  = (c == CharOpen);
    r.close = (c == CharClose);
    r.xchar = (c == CharLoX) || (c == CharUpX);
    r.zero  = (c == CharZero);
    r.dec   = (c >= CharZero) && (c <= CharNine);
    lo_hex  = (c >= CharLoA) && (c <= CharLoF);
    up_hex  = (c >= CharUpA) && (c <= CharUpF);
    r.hex   = r.dec || lo_hex || up_hex;
    r.digit = r.dec ? c[3:0] : c[3:0] + 4'd9;
    return r;
  endfunction

endpackage

>>> rtl/init_record_text_parser.sv
// init record text parser: one text byte per cycle in, up to two results per byte out
// a byte is written to the input queue, then its results to the result queue
// throughput: one byte per cycle while the result queue has room for two results
// results drain one per cycle while pop is high; the parser waits while more than two results are queued
// reset: asynchronous, clears queues and parser state to seeking an open brace
// depends on irtp_pkg, irtp_front, irtp_back, irtp_outq
module init_record_text_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte_i,
  input  logic        first_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind_o,
  output logic [31:0] value_o,
  output logic [6:0]  data_index_o,
  output logic [5:0]  record_slot_o,
  output logic        last_o
);

  irtp_pkg::char_t   item;
  irtp_pkg::result_t res0, res1, head;
  logic              item_valid, take, room;
  logic [1:0]        res_n;
  logic [irtp_pkg::OutQCntW-1:0] oq_count;

  irtp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .text_byte_i  (text_byte_i),
    .first_byte_i (first_byte_i),
    .full         (full),
    .valid_o      (item_valid),
    .item_o       (item),
    .take_i       (take)
  );

  irtp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (item_valid),
    .item_i  (item),
    .take_o  (take),
    .room_i  (room),
    .res_n_o (res_n),
    .res0_o  (res0),
    .res1_o  (res1)
  );

  irtp_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_n_i  (res_n),
    .wr0_i   (res0),
    .wr1_i   (res1),
    .pop_i   (pop),
    .empty   (empty),
    .head_o  (head),
    .room_o  (room),
    .count_o (oq_count)
  );

  assign kind_o        = head.kind;
  assign value_o       = head.value;
  assign data_index_o  = head.data_index;
  assign record_slot_o = head.record_slot;
  assign last_o        = head.last;

  a_room_on_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> oq_count <= irtp_pkg::OutQCntW'(irtp_pkg::OutQDepth - 2))
    else $error("parser advanced without room for two results");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_count <= irtp_pkg::OutQCntW'(irtp_pkg::OutQDepth))
    else $error("result queue overflow");

  a_pair_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !last_o) |-> oq_count >= irtp_pkg::OutQCntW'(2))
    else $error("non-final result without its follower queued");

endmodule

>>> rtl/irtp_front.sv
// front end: classifies incoming text bytes and buffers them in a short queue
// depends on irtp_pkg
module irtp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic [7:0]      text_byte_i,
  input  logic            first_byte_i,
  output logic            full,
  output logic            valid_o,
  output irtp_pkg::char_t item_o,
  input  logic            take_i
);

  irtp_pkg::char_t mem_q [irtp_pkg::InQDepth];
  logic [irtp_pkg::InQAw-1:0]   wp_q, rp_q;
  logic [irtp_pkg::InQCntW-1:0] cnt_q, cnt_d;
  logic wr, rd;

  assign full    = (cnt_q == irtp_pkg::InQCntW'(irtp_pkg::InQDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rp_q];
  assign wr      = push_i && !full;
  assign rd      = take_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (wr && !rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd && !wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr) begin
        wp_q <= wp_q + 1'b1;
      end
      if (rd) begin
        rp_q <= rp_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= irtp_pkg::classify(text_byte_i, first_byte_i);
    end
  end

endmodule

>>> rtl/irtp_back.sv
// back end: record parser state machine, produces up to two results per character
// depends on irtp_pkg
module irtp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  irtp_pkg::char_t   item_i,
  output logic              take_o,
  input  logic              room_i,
  output logic [1:0]        res_n_o,
  output irtp_pkg::result_t res0_o,
  output irtp_pkg::result_t res1_o
);

  typedef enum logic [2:0] {
    ModeSeek,
    ModeOpen,
    ModeDigits,
    ModeZero,
    ModePfx,
    ModeSkip,
    ModeEnd
  } mode_e;

  mode_e                        mode_q, mode_d, mode;
  logic [31:0]                  acc_q, acc_d, acc;
  logic [irtp_pkg::ValCntW-1:0] vc_q, vc_d, vc, vc_inc, cvc, data_off;
  logic [irtp_pkg::RecCntW-1:0] rc_q, rc_d, rc;
  logic                         hexm_q, hexm_d, hexm;

  logic            emit_val, emit_stat, fin_emit;
  irtp_pkg::kind_e val_kind, stat_kind, close_kind;
  logic [31:0]     val_value;
  logic [6:0]      val_idx;
  logic            close_ok;
  logic            delim;
  logic [31:0]     acc_dec, acc_hex;
  irtp_pkg::result_t rv, rs;

  assign take_o = valid_i && room_i;

  always_comb begin
    mode = item_i.first ? ModeSeek : mode_q;
    acc  = item_i.first ? '0 : acc_q;
    vc   = item_i.first ? '0 : vc_q;
    rc   = item_i.first ? '0 : rc_q;
    hexm = item_i.first ? 1'b0 : hexm_q;

    delim   = item_i.space || item_i.comma || item_i.close;
    acc_dec = {acc[28:0], 3'b000} + {acc[30:0], 1'b0} + {28'd0, item_i.digit};
    acc_hex = {acc[27:0], item_i.digit};

    // value count after a number ends
    vc_inc   = (vc < irtp_pkg::ValCntW'(irtp_pkg::ValCntMax)) ? vc + 1'b1 : vc;
    data_off = vc_inc - irtp_pkg::ValCntW'(3);
    val_value = {24'd0, acc[7:0]};
    val_idx   = '0;
    fin_emit  = 1'b1;
    if (vc_inc == irtp_pkg::ValCntW'(1)) begin
      val_kind  = irtp_pkg::KindDelay;
      val_value = acc;
    end else if (vc_inc == irtp_pkg::ValCntW'(2)) begin
      val_kind = irtp_pkg::KindCmd;
    end else begin
      val_kind = irtp_pkg::KindData;
      val_idx  = 7'(data_off);
      fin_emit = (data_off < irtp_pkg::ValCntW'(irtp_pkg::MaxDataBytes));
    end

    // closing brace status
    cvc      = (mode == ModeOpen) ? vc : vc_inc;
    close_ok = 1'b0;
    if (cvc < irtp_pkg::ValCntW'(2)) begin
      close_kind = irtp_pkg::KindFew;
    end else if (cvc > irtp_pkg::ValCntW'(irtp_pkg::MaxDataBytes + 2)) begin
      close_kind = irtp_pkg::KindMany;
    end else if (rc >= irtp_pkg::RecCntW'(irtp_pkg::MaxRecords)) begin
      close_kind = irtp_pkg::KindFull;
    end else begin
      close_kind = irtp_pkg::KindOk;
      close_ok   = 1'b1;
    end

    mode_d    = mode;
    acc_d     = acc;
    vc_d      = vc;
    rc_d      = rc;
    hexm_d    = hexm;
    emit_val  = 1'b0;
    emit_stat = 1'b0;
    stat_kind = irtp_pkg::KindSyntax;

    case (mode)
      ModeSeek: begin
        if (item_i.nul) begin
          mode_d = ModeEnd;
        end else if (item_i.space) begin
          mode_d = ModeSeek;
        end else if (item_i.open) begin
          mode_d = ModeOpen;
          vc_d   = '0;
          hexm_d = 1'b0;
        end else begin
          emit_stat = 1'b1;
          mode_d    = ModeSkip;
        end
      end
      ModeOpen: begin
        if (item_i.space || item_i.comma) begin
          mode_d = ModeOpen;
        end else if (item_i.close) begin
          emit_stat = 1'b1;
          stat_kind = close_kind;
          mode_d    = ModeSkip;
          if (close_ok) begin
            rc_d = rc + 1'b1;
          end
        end else if (item_i.zero) begin
          mode_d = ModeZero;
          acc_d  = '0;
        end else if (item_i.dec) begin
          mode_d = ModeDigits;
          hexm_d = 1'b0;
          acc_d  = {28'd0, item_i.digit};
        end else begin
          emit_stat = 1'b1;
          mode_d    = item_i.nul ? ModeEnd : ModeSkip;
        end
      end
      ModeZero, ModeDigits: begin
        if (mode == ModeZero && item_i.xchar) begin
          mode_d = ModePfx;
        end else if (mode == ModeZero && item_i.dec) begin
          mode_d = ModeDigits;
          hexm_d = 1'b0;
          acc_d  = {28'd0, item_i.digit};
        end else if (mode == ModeDigits && hexm && item_i.hex) begin
          acc_d = acc_hex;
        end else if (mode == ModeDigits && !hexm && item_i.dec) begin
          acc_d = acc_dec;
        end else if (delim) begin
          vc_d     = vc_inc;
          emit_val = fin_emit;
          mode_d   = ModeOpen;
          hexm_d   = 1'b0;
          if (item_i.close) begin
            emit_stat = 1'b1;
            stat_kind = close_kind;
            mode_d    = ModeSkip;
            if (close_ok) begin
              rc_d = rc + 1'b1;
            end
          end
        end else begin
          emit_stat = 1'b1;
          mode_d    = item_i.nul ? ModeEnd : ModeSkip;
        end
      end
      ModePfx: begin
        if (item_i.hex) begin
          mode_d = ModeDigits;
          hexm_d = 1'b1;
          acc_d  = {28'd0, item_i.digit};
        end else begin
          emit_stat = 1'b1;
          mode_d    = item_i.nul ? ModeEnd : ModeSkip;
        end
      end
      ModeSkip: begin
        if (item_i.nul) begin
          mode_d = ModeEnd;
        end else if (item_i.newline) begin
          mode_d = ModeSeek;
        end
      end
      default: begin
        mode_d = ModeEnd;
      end
    endcase

    rv.kind        = val_kind;
    rv.value       = val_value;
    rv.data_index  = val_idx;
    rv.record_slot = 6'(rc);
    rv.last        = !emit_stat;
    rs.kind        = stat_kind;
    rs.value       = '0;
    rs.data_index  = '0;
    rs.record_slot = 6'(rc);
    rs.last        = 1'b1;

    res0_o  = emit_val ? rv : rs;
    res1_o  = rs;
    res_n_o = {1'b0, emit_val} + {1'b0, emit_stat};
    if (!take_o) begin
      res_n_o = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeSeek;
      acc_q  <= '0;
      vc_q   <= '0;
      rc_q   <= '0;
      hexm_q <= 1'b0;
    end else if (take_o) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      vc_q   <= vc_d;
      rc_q   <= rc_d;
      hexm_q <= hexm_d;
    end
  end

endmodule

>>> rtl/irtp_outq.sv
// result queue: takes up to two results per cycle, hands out one per cycle while popped
// depends on irtp_pkg
module irtp_outq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [1:0]                      wr_n_i,
  input  irtp_pkg::result_t               wr0_i,
  input  irtp_pkg::result_t               wr1_i,
  input  logic                            pop_i,
  output logic                            empty,
  output irtp_pkg::result_t               head_o,
  output logic                            room_o,
  output logic [irtp_pkg::OutQCntW-1:0]   count_o
);

  irtp_pkg::result_t mem_q [irtp_pkg::OutQDepth];
  logic [irtp_pkg::OutQAw-1:0]   wp_q, rp_q, wp1;
  logic [irtp_pkg::OutQCntW-1:0] cnt_q;
  logic rd;

  assign empty   = (cnt_q == '0);
  assign head_o  = mem_q[rp_q];
  assign room_o  = (cnt_q <= irtp_pkg::OutQCntW'(irtp_pkg::OutQDepth - 2));
  assign count_o = cnt_q;
  assign rd      = pop_i && !empty;
  assign wp1     = wp_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + irtp_pkg::OutQAw'(wr_n_i);
      cnt_q <= cnt_q + irtp_pkg::OutQCntW'(wr_n_i) - irtp_pkg::OutQCntW'(rd);
      if (rd) begin
        rp_q <= rp_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_n_i != 2'd0) begin
      mem_q[wp_q] <= wr0_i;
    end
    if (wr_n_i == 2'd2) begin
      mem_q[wp1] <= wr1_i;
    end
  end

endmodule

>>> bench/init_record_text_parser_test.sv
// self-checking bench for the init record text parser: queued text bytes in, parse results out
// predicts every result of each accepted byte and compares them in order
// depends on irtp_pkg and init_record_text_parser
module init_record_text_parser_test;
  import irtp_pkg::*;

  localparam int IdleLimit = 4000;

  typedef enum int {
    ScanSeek, ScanOpen, ScanDigits, ScanZero, ScanPrefix, ScanSkip, ScanEnd
  } scan_mode_e;

  typedef struct {
    logic [7:0] ch;
    logic       first;
    bit         hold;
  } text_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  text_byte_i = 8'h00;
  logic        first_byte_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  kind_o;
  logic [31:0] value_o;
  logic [6:0]  data_index_o;
  logic [5:0]  record_slot_o;
  logic        last_o;

  text_req_t  pending_chars[$];
  text_req_t  draft[$];
  result_t    awaited_results[$];
  result_t    byte_results[$];
  bit         fresh_seq;
  bit         hold_next;
  int         mismatches;
  int         stuck_cycles;
  int         burst_left;
  int         gap_left;
  int         pop_left;
  int         pop_mode;

  scan_mode_e  scan_mode = ScanSeek;
  logic [31:0] number_acc = '0;
  int          value_cnt;
  int          stored_cnt;
  bit          in_hex;

  init_record_text_parser uut (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .text_byte_i,
    .first_byte_i,
    .empty,
    .pop,
    .kind_o,
    .value_o,
    .data_index_o,
    .record_slot_o,
    .last_o
  );

  always #1 clk_i = ~clk_i;

  function automatic bit is_blank(logic [7:0] c);
    return c == CharSp || c == CharTab || c == CharNl || c == CharVt || c == CharFf ||
           c == CharCr;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CharZero && c <= CharNine;
  endfunction

  function automatic bit is_delim(logic [7:0] c);
    return is_blank(c) || c == CharComma || c == CharClose;
  endfunction

  function automatic int hex_nibble(logic [7:0] c);
    if (is_digit(c)) return c - CharZero;
    if (c >= CharLoA && c <= CharLoF) return c - CharLoA + 10;
    if (c >= CharUpA && c <= CharUpF) return c - CharUpA + 10;
    return -1;
  endfunction

  function automatic void note_result(kind_e k, logic [31:0] v, int idx);
    result_t r;
    r.kind        = k;
    r.value       = v;
    r.data_index  = idx[6:0];
    r.record_slot = stored_cnt[5:0];
    r.last        = 1'b0;
    byte_results.push_back(r);
  endfunction

  function automatic void reject_record(logic [7:0] c);
    note_result(KindSyntax, '0, 0);
    scan_mode = (c == CharNul) ? ScanEnd : ScanSkip;
  endfunction

  function automatic void close_record();
    if (value_cnt < 2) begin
      note_result(KindFew, '0, 0);
    end else if (value_cnt - 2 > MaxDataBytes) begin
      note_result(KindMany, '0, 0);
    end else if (stored_cnt >= MaxRecords) begin
      note_result(KindFull, '0, 0);
    end else begin
      note_result(KindOk, '0, 0);
      stored_cnt++;
    end
    scan_mode = ScanSkip;
  endfunction

  function automatic void finish_value(logic [7:0] c);
    if (value_cnt < MaxDataBytes + 3) value_cnt++;
    if (value_cnt == 1) begin
      note_result(KindDelay, number_acc, 0);
    end else if (value_cnt == 2) begin
      note_result(KindCmd, {24'h0, number_acc[7:0]}, 0);
    end else if (value_cnt - 3 < MaxDataBytes) begin
      note_result(KindData, {24'h0, number_acc[7:0]}, value_cnt - 3);
    end
    scan_mode = ScanOpen;
    in_hex = 1'b0;
    if (c == CharClose) close_record();
  endfunction

  // expected results of one accepted request
  function automatic void parse_char(logic [7:0] c, logic first);
    int nib;
    byte_results.delete();
    if (first) begin
      scan_mode  = ScanSeek;
      number_acc = '0;
      value_cnt  = 0;
      stored_cnt = 0;
      in_hex     = 1'b0;
    end
    nib = hex_nibble(c);
    case (scan_mode)
      ScanSeek: begin
        if (c == CharNul) begin
          scan_mode = ScanEnd;
        end else if (c == CharOpen) begin
          scan_mode = ScanOpen;
          value_cnt = 0;
          in_hex    = 1'b0;
        end else if (!is_blank(c)) begin
          reject_record(c);
        end
      end
      ScanOpen: begin
        if (c == CharClose) begin
          close_record();
        end else if (c == CharZero) begin
          scan_mode  = ScanZero;
          number_acc = '0;
        end else if (is_digit(c)) begin
          scan_mode  = ScanDigits;
          in_hex     = 1'b0;
          number_acc = {24'h0, c - CharZero};
        end else if (!(is_blank(c) || c == CharComma)) begin
          reject_record(c);
        end
      end
      ScanZero: begin
        if (c == CharLoX || c == CharUpX) begin
          scan_mode = ScanPrefix;
        end else if (is_digit(c)) begin
          scan_mode  = ScanDigits;
          in_hex     = 1'b0;
          number_acc = {24'h0, c - CharZero};
        end else if (is_delim(c)) begin
          finish_value(c);
        end else begin
          reject_record(c);
        end
      end
      ScanPrefix: begin
        if (nib >= 0) begin
          scan_mode  = ScanDigits;
          in_hex     = 1'b1;
          number_acc = {28'h0, 4'(nib)};
        end else begin
          reject_record(c);
        end
      end
      ScanDigits: begin
        if (in_hex && nib >= 0) begin
          number_acc = {number_acc[27:0], 4'(nib)};
        end else if (!in_hex && is_digit(c)) begin
          number_acc = number_acc * 32'd10 + {24'h0, c - CharZero};
        end else if (is_delim(c)) begin
          finish_value(c);
        end else begin
          reject_record(c);
        end
      end
      ScanSkip: begin
        if (c == CharNul) scan_mode = ScanEnd;
        else if (c == CharNl) scan_mode = ScanSeek;
      end
      default: scan_mode = ScanEnd;
    endcase
    if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
    foreach (byte_results[i]) awaited_results.push_back(byte_results[i]);
  endfunction

  // text generation
  function automatic void put_char(logic [7:0] b);
    text_req_t r;
    r.ch    = b;
    r.first = 1'b0;
    r.hold  = 1'b0;
    draft.push_back(r);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endfunction

  function automatic void put_gap();
    case ($urandom_range(0, 7))
      0, 1: put_char(CharComma);
      2: put_char(CharSp);
      3: begin
        put_char(CharComma);
        put_char(CharSp);
      end
      4: begin
        put_char(CharSp);
        put_char(CharComma);
        put_char(CharTab);
      end
      5: put_char(CharTab);
      6: put_char($urandom_range(0, 1) ? CharCr : ($urandom_range(0, 1) ? CharVt : CharFf));
      default: put_char(CharNl);
    endcase
  endfunction

  function automatic string number_text();
    string s;
    case ($urandom_range(0, 9))
      0: s = "0";
      1, 2: s = $sformatf("%0d", $urandom_range(1, 300));
      3: s = $sformatf("%0d", $urandom);
      4: s = $sformatf("%0d", {$urandom, $urandom});
      5, 6, 7: begin
        if ($urandom_range(0, 2) == 0) s = $sformatf("%0h", {$urandom, $urandom});
        else s = $sformatf("%0h", $urandom);
        if ($urandom_range(0, 1)) s = s.toupper();
        if ($urandom_range(0, 1)) s = {"0X", s};
        else s = {"0x", s};
      end
      8: s = {"0", $sformatf("%0d", $urandom_range(0, 999))};
      default: s = {"0x", $sformatf("%0h", $urandom_range(0, 255))};
    endcase
    return s;
  endfunction

  function automatic void commit_draft();
    bit saw_nul;
    saw_nul = 1'b0;
    foreach (draft[i]) begin
      if (fresh_seq) draft[i].first = 1'b1;
      if (hold_next) draft[i].hold = 1'b1;
      fresh_seq = 1'b0;
      hold_next = 1'b0;
      if (draft[i].ch == CharNul) saw_nul = 1'b1;
      pending_chars.push_back(draft[i]);
    end
    draft.delete();
    // after end of text nothing parses until a fresh sequence
    if (saw_nul) fresh_seq = 1'b1;
  endfunction

  function automatic void gen_record(int nvals, bit compact, bit noisy);
    int        k;
    text_req_t junk;
    draft.delete();
    repeat ($urandom_range(0, 2)) put_char($urandom_range(0, 1) ? CharSp : CharNl);
    put_char(CharOpen);
    if (!compact && $urandom_range(0, 3) == 0) put_gap();
    for (int i = 0; i < nvals; i++) begin
      if (compact) put_char(CharZero + 8'($urandom_range(0, 9)));
      else put_text(number_text());
      if (i < nvals - 1) begin
        if (compact) put_char(CharComma);
        else put_gap();
      end else if (!compact && $urandom_range(0, 1)) begin
        put_gap();
      end
    end
    put_char(CharClose);
    if (!compact && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) put_char(8'($urandom_range(33, 126)));
    end
    put_char(CharNl);
    if (noisy) begin
      k = $urandom_range(0, draft.size() - 1);
      junk.ch    = 8'($urandom_range(0, 255));
      junk.first = 1'b0;
      junk.hold  = 1'b0;
      case ($urandom_range(0, 3))
        0: draft[k].ch = junk.ch;
        1: draft.insert(k, junk);
        2: draft[k].ch = CharNul;
        default: draft[k].first = 1'b1;
      endcase
    end
    commit_draft();
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    bit go;
    if (!rst_ni) begin
      push         <= 1'b0;
      text_byte_i  <= 8'h00;
      first_byte_i <= 1'b0;
    end else begin
      if (push && !full) begin
        parse_char(text_byte_i, first_byte_i);
        void'(pending_chars.pop_front());
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left   = $urandom_range(0, 7);
      end
      go = gap_left == 0 && pending_chars.size() > 0 &&
           !(pending_chars[0].hold && awaited_results.size() != 0);
      if (go) begin
        burst_left--;
        text_byte_i  <= pending_chars[0].ch;
        first_byte_i <= pending_chars[0].first;
      end
      push <= go;
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    result_t want;
    bit      ready;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: kind %0d value %0h", kind_o, value_o);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (kind_o !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind_o);
            mismatches++;
          end
          if (value_o !== want.value) begin
            $error("value: expected %0h, got %0h", want.value, value_o);
            mismatches++;
          end
          if (data_index_o !== want.data_index) begin
            $error("data_index: expected %0d, got %0d", want.data_index, data_index_o);
            mismatches++;
          end
          if (record_slot_o !== want.record_slot) begin
            $error("record_slot: expected %0d, got %0d", want.record_slot, record_slot_o);
            mismatches++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last_o);
            mismatches++;
          end
        end
      end
      if (pop_left == 0) begin
        pop_left = $urandom_range(16, 96);
        pop_mode = $urandom_range(0, 3);
      end
      pop_left--;
      case (pop_mode)
        0, 1: ready = 1'b1;
        2: ready = $urandom_range(0, 1);
        default: ready = $urandom_range(0, 3) == 0;
      endcase
      pop <= ready;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int stop_at;
    fresh_seq = 1'b1;
    draft.delete();
    put_text("{0xFFFFFFFF,0X1fF}\n{9}\nx\n{0x}\n{0");
    put_char(CharNul);
    put_char(CharOpen);
    commit_draft();

    // fill the record table and run past it
    fresh_seq = 1'b1;
    for (int i = 0; i < MaxRecords + 3; i++) gen_record($urandom_range(2, 3), 1'b1, 1'b0);
    gen_record(MaxDataBytes + $urandom_range(3, 8), 1'b1, 1'b0);

    fresh_seq = 1'b1;
    hold_next = 1'b1;
    stop_at = pending_chars.size() + 450;
    while (pending_chars.size() < stop_at) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: gen_record($urandom_range(2, 8), 1'b0, 1'b0);
        12, 13: gen_record($urandom_range(0, 1), 1'b0, 1'b0);
        14, 15, 16: gen_record($urandom_range(0, 6), 1'b0, 1'b1);
        17: begin
          draft.delete();
          repeat ($urandom_range(1, 6)) put_char(8'($urandom_range(0, 255)));
          put_char(CharNl);
          commit_draft();
        end
        18: begin
          fresh_seq = 1'b1;
          hold_next = $urandom_range(0, 1);
        end
        default: begin
          draft.delete();
          put_char(CharNul);
          repeat ($urandom_range(0, 3)) put_char(8'($urandom_range(0, 255)));
          commit_draft();
        end
      endcase
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_chars.size() != 0 || awaited_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
